// ===== rtl/core/swtm_pkg.sv =====
`default_nettype none
package swtm_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned NumCh = 4;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 6;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_REPORT = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_REPORT_IVL = 2'd0,
    CFG_SAMPLE_IVL = 2'd1,
    CFG_REFRESH    = 2'd2,
    CFG_MIN_SMP    = 2'd3
  } cfg_e;

  // lane control from the sequencer
  typedef struct packed {
    logic clear;
    logic acc;
    logic div_start;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/swtm_lane.sv =====
`default_nettype none
// one channel: running sum, min and max, plus a serial rounding divider
module swtm_lane import swtm_pkg::*; #(
  parameter int unsigned SumW = 21
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lane_ctl_t              ctl_i,
  input  wire logic signed [DataW-1:0] val_i,
  input  wire logic [SumW-1:0]        den_i,
  output logic                        busy_o,
  output logic signed [DataW-1:0]     mean_o
);

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic signed [SumW-1:0]  sum_q;
  logic signed [DataW-1:0] min_q, max_q;
  logic [SumW-1:0]         num_q, quo_q, den_q;
  logic [SumW:0]           rem_q;
  logic                    neg_q, busy_q;
  logic [StepW-1:0]        step_q;

  logic signed [SumW+1:0] trim;
  logic [SumW+1:0]        mag;
  logic [SumW:0]          shifted;
  logic                   fits;

  always_comb begin
    trim = {{2{sum_q[SumW-1]}}, sum_q}
         - {{(SumW+2-DataW){min_q[DataW-1]}}, min_q}
         - {{(SumW+2-DataW){max_q[DataW-1]}}, max_q};
    mag = trim[SumW+1] ? -trim : trim;
    shifted = {rem_q[SumW-1:0], num_q[SumW-1]};
    fits = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      min_q  <= {1'b0, {(DataW-1){1'b1}}};
      max_q  <= {1'b1, {(DataW-1){1'b0}}};
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (ctl_i.clear) begin
      sum_q <= '0;
      min_q <= {1'b0, {(DataW-1){1'b1}}};
      max_q <= {1'b1, {(DataW-1){1'b0}}};
    end else if (ctl_i.acc) begin
      sum_q <= sum_q + {{(SumW-DataW){val_i[DataW-1]}}, val_i};
      if (val_i < min_q) min_q <= val_i;
      if (val_i > max_q) max_q <= val_i;
    end else if (ctl_i.div_start) begin
      // numerator is |sum - min - max| + d/2, restoring division one bit a cycle
      busy_q <= 1'b1;
      step_q <= StepW'(SumW);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == StepW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      neg_q <= trim[SumW+1];
      num_q <= mag[SumW-1:0] + {1'b0, den_i[SumW-1:1]};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? shifted - {1'b0, den_q} : shifted;
      quo_q <= {quo_q[SumW-2:0], fits};
      num_q <= {num_q[SumW-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign mean_o = neg_q ? -quo_q[DataW-1:0] : quo_q[DataW-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/sensor_window_trimmed_mean.sv =====
`default_nettype none
// windowed trimmed mean over four sensor channels
// in channel: req_type_i, now_i, four readings, reading_ok_i, qualified by
//   in_valid_i and in_stall_o; out channel: ok_o, window_closed_o and four means,
//   qualified by out_valid_o and out_stall_i
// one item gives exactly one result item
// start, sample and reading items and a report that is not yet due have their
//   result registered; it appears the cycle after acceptance
// the window roll needs elapsed / interval, done by a single 32-step serial
//   divider; a due report that is not usable has its result registered when
//   the divider finishes
// a usable report then runs four lanes in parallel, each a one-bit-a-cycle
//   restoring divider over the 22-bit trimmed sum, and its result is registered
//   once all four lanes are done
// one item is held at a time: in_stall_o is high while an item is in work or
//   its result still waits in the output register, so a new item is accepted
//   only after the result of the last one has been taken
// reset restores the register defaults, clears the window and accumulators
// a stalled receiver simply holds the result; no item is lost
module sensor_window_trimmed_mean import swtm_pkg::*; #(
  parameter int unsigned MaxSamples = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_index_i,
  input  wire logic [31:0]             cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              req_type_i,
  input  wire logic [TimeW-1:0]        now_i,
  input  wire logic signed [DataW-1:0] in_temp_a_i,
  input  wire logic signed [DataW-1:0] in_hum_a_i,
  input  wire logic signed [DataW-1:0] in_temp_b_i,
  input  wire logic signed [DataW-1:0] in_hum_b_i,
  input  wire logic                    reading_ok_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         ok_o,
  output logic                         window_closed_o,
  output logic signed [DataW-1:0]      mean_temp_a_o,
  output logic signed [DataW-1:0]      mean_hum_a_o,
  output logic signed [DataW-1:0]      mean_temp_b_o,
  output logic signed [DataW-1:0]      mean_hum_b_o
);

  localparam int unsigned SmpW = $clog2(MaxSamples + 1);
  localparam int unsigned SumW = DataW + SmpW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WDIV = 4'b0010,
    ST_MDIV = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q;

  // configuration
  logic [TimeW-1:0] rep_ivl_q, smp_ivl_q, refresh_q;
  logic [CntW-1:0]  min_smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_ivl_q <= 32'd60000;
      smp_ivl_q <= 32'd5000;
      refresh_q <= 32'd2000;
      min_smp_q <= 6'd3;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_REPORT_IVL: rep_ivl_q <= cfg_data_i;
        CFG_SAMPLE_IVL: smp_ivl_q <= cfg_data_i;
        CFG_REFRESH:    refresh_q <= cfg_data_i;
        CFG_MIN_SMP:    min_smp_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // window state
  logic [TimeW-1:0] win_start_q, last_smp_q, last_rd_q;
  logic             has_smp_q, has_rd_q, pend_q;
  logic [SmpW-1:0]  count_q;

  logic [TimeW-1:0] ivl, elapsed, d_smp, d_rd;
  logic             accept, deny, rd_take, due;
  logic             ok_idle;
  req_e             req;

  assign accept  = in_valid_i && !in_stall_o;
  assign req     = req_e'(req_type_i);
  assign ivl     = (rep_ivl_q == '0) ? 32'd1 : rep_ivl_q;
  assign elapsed = now_i - win_start_q;
  assign d_smp   = now_i - last_smp_q;
  assign d_rd    = now_i - last_rd_q;
  assign deny    = pend_q || ({1'b0, count_q} >= (SmpW+1)'(MaxSamples))
                 || elapsed >= (ivl - refresh_q)
                 || (has_smp_q && d_smp < smp_ivl_q)
                 || (has_rd_q && d_rd < refresh_q);
  assign rd_take = pend_q && elapsed < ivl && reading_ok_i
                 && ({1'b0, count_q} < (SmpW+1)'(MaxSamples));
  assign due     = elapsed >= ivl;

  // ok flag of a start, sample or reading item; a report sets it later if usable
  always_comb begin
    case (req)
      REQ_START:  ok_idle = 1'b1;
      REQ_SAMPLE: ok_idle = !deny;
      REQ_READ:   ok_idle = rd_take;
      default:    ok_idle = 1'b0;
    endcase
  end

  // window count divider: elapsed / ivl, one quotient bit a cycle
  logic [TimeW-1:0] wnum_q, wquo_q, wdiv_q;
  logic [TimeW:0]   wrem_q, wsh;
  logic [5:0]       wstep_q;
  logic             wfit;
  assign wsh  = {wrem_q[TimeW-1:0], wnum_q[TimeW-1]};
  assign wfit = wsh >= {1'b0, wdiv_q};

  // lanes
  lane_ctl_t lane_ctl;
  logic [NumCh-1:0] lane_busy;
  logic signed [DataW-1:0] vals [NumCh];
  logic signed [DataW-1:0] means [NumCh];
  logic [SumW-1:0] den;

  assign vals[0] = in_temp_a_i;
  assign vals[1] = in_hum_a_i;
  assign vals[2] = in_temp_b_i;
  assign vals[3] = in_hum_b_i;
  assign den = SumW'(count_q) - SumW'(2);

  logic usable;
  assign usable = (wquo_q == 32'd1) && (count_q >= SmpW'(3))
                && (32'(min_smp_q) <= 32'(count_q));

  always_comb begin
    lane_ctl.clear     = (accept && req == REQ_START)
                       || (state_q == ST_WDIV && wstep_q == '0 && !usable)
                       || (state_q == ST_MDIV && lane_busy == '0);
    lane_ctl.acc       = accept && req == REQ_READ && rd_take;
    lane_ctl.div_start = state_q == ST_WDIV && wstep_q == '0 && usable;
  end

  for (genvar c = 0; c < NumCh; c++) begin : g_lane
    swtm_lane #(.SumW(SumW)) u_lane (
      .clk_i, .rst_ni, .ctl_i(lane_ctl), .val_i(vals[c]), .den_i(den),
      .busy_o(lane_busy[c]), .mean_o(means[c])
    );
  end

  // result register
  logic             ok_q, closed_q;
  logic [DataW-1:0] m_q [NumCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_start_q <= '0;
      last_smp_q  <= '0;
      last_rd_q   <= '0;
      has_smp_q   <= 1'b0;
      has_rd_q    <= 1'b0;
      pend_q      <= 1'b0;
      count_q     <= '0;
      wstep_q     <= '0;
      ok_q        <= 1'b0;
      closed_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ok_q     <= ok_idle;
            closed_q <= 1'b0;
            state_q  <= ST_OUT;
            case (req)
              REQ_START: begin
                win_start_q <= now_i;
                has_smp_q   <= 1'b0;
                has_rd_q    <= 1'b0;
                pend_q      <= 1'b0;
                count_q     <= '0;
              end
              REQ_SAMPLE: begin
                if (!deny) begin
                  last_smp_q <= now_i;
                  has_smp_q  <= 1'b1;
                  pend_q     <= 1'b1;
                end
              end
              REQ_READ: begin
                if (pend_q) begin
                  pend_q    <= 1'b0;
                  last_rd_q <= now_i;
                  has_rd_q  <= 1'b1;
                  if (rd_take) begin
                    count_q <= count_q + 1'b1;
                  end
                end
              end
              REQ_REPORT: begin
                if (due) begin
                  wstep_q <= 6'd32;
                  state_q <= ST_WDIV;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WDIV: begin
          if (wstep_q != '0) begin
            wstep_q <= wstep_q - 1'b1;
          end else begin
            // roll by whole windows; multiply once, 32x32 truncated
            win_start_q <= win_start_q + TimeW'(wquo_q * wdiv_q);
            pend_q      <= 1'b0;
            closed_q    <= 1'b1;
            if (usable) begin
              state_q <= ST_MDIV;
            end else begin
              count_q <= '0;
              state_q <= ST_OUT;
            end
          end
        end
        ST_MDIV: begin
          if (lane_busy == '0) begin
            ok_q    <= 1'b1;
            count_q <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wnum_q <= elapsed;
      wdiv_q <= ivl;
      wrem_q <= '0;
      wquo_q <= '0;
    end else if (state_q == ST_WDIV && wstep_q != '0) begin
      wrem_q <= wfit ? wsh - {1'b0, wdiv_q} : wsh;
      wquo_q <= {wquo_q[TimeW-2:0], wfit};
      wnum_q <= {wnum_q[TimeW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int c = 0; c < NumCh; c++) m_q[c] <= '0;
    end else if (state_q == ST_MDIV && lane_busy == '0) begin
      for (int c = 0; c < NumCh; c++) m_q[c] <= means[c];
    end
  end

  assign in_stall_o      = state_q != ST_IDLE;
  assign out_valid_o     = state_q == ST_OUT;
  assign ok_o            = ok_q;
  assign window_closed_o = closed_q;
  assign mean_temp_a_o   = m_q[0];
  assign mean_hum_a_o    = m_q[1];
  assign mean_temp_b_o   = m_q[2];
  assign mean_hum_b_o    = m_q[3];

  // checks
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o))
    else $error("result changed under stall");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("item accepted while result pending");
  a_closed_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o && (mean_temp_a_o != '0) |-> window_closed_o)
    else $error("means without closed window");

endmodule
`default_nettype wire
